/* design/trpd_pkg.sv */
// shared constants and codes for the tile run-length plane decoder
package trpd_pkg;

    // tile geometry limits
    localparam int TILE_EDGE  = 64;
    localparam int MAX_PLANES = 4;

    // field widths
    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int PLANE_W = 2;
    localparam int POS_W   = 6;
    localparam int KIND_W  = 2;
    localparam int DIM_W   = 7;
    localparam int NP_W    = 3;
    localparam int CNT_W   = 16;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int M_DATA_W   = 24;

    // input item modes
    localparam logic [MODE_W-1:0] MODE_BYTE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PULL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEW  = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROP_IN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP_END = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BPP         = 2'd2;

    // opcode header bytes
    localparam logic [BYTE_W-1:0] HDR_SHORT_RUN_MAX = 8'd126;
    localparam logic [BYTE_W-1:0] HDR_LONG_RUN      = 8'd127;
    localparam logic [BYTE_W-1:0] HDR_LONG_LIT      = 8'd128;

    // decoder phases
    localparam logic [PHASE_W-1:0] PH_HDR = 3'd0;
    localparam logic [PHASE_W-1:0] PH_VAL = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RHI = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RLO = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CHI = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CLO = 3'd5;
    localparam logic [PHASE_W-1:0] PH_LIT = 3'd6;
    localparam logic [PHASE_W-1:0] PH_RUN = 3'd7;

    typedef logic [DIM_W-1:0] dim_t;

    // clamp a register value into 1..hi
    function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
        dim_t r;
        if (v == '0) begin
            r = dim_t'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* design/tile_rle_plane_decoder.sv */
// run-length tile plane decoder with stream ports and a result register
//
// Takes one item per clock: a compressed byte, a pull of the next run byte,
// or a new-tile start. Each item is decoded in the cycle it is accepted and
// its result, if any, lands in the output register, so items flow back to
// back whenever s_tready is high; s_tready drops only while a result is held
// in the output register and m_tready is low. Literal bytes are written as
// they arrive, run bytes one per pull; each write carries its plane, row and
// column. Bytes arriving while a run is pending or after the tile is done
// come back as dropped items; writes beyond the plane end are flagged, not
// placed. The user must write tile width, height and plane count on the cfg
// port only while idle (not enforced by the block); clamped to 1..64, 1..64, 1..4.
module tile_rle_plane_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [trpd_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] stream_byte
    input  logic [trpd_pkg::MODE_W-1:0]       s_tuser,  // [1:0] mode
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] pixel_value, [9:8] plane, [15:10] tile_row, [21:16] tile_col, [23:22] zero
    output logic [trpd_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [trpd_pkg::KIND_W-1:0]       m_tuser,  // [1:0] kind
    output logic                              m_tlast   // last
);
    import trpd_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]   tile_width_reg;
    logic [DIM_W-1:0]   tile_height_reg;
    logic [NP_W-1:0]    bpp_reg;

    // decoder state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   remaining_reg, remaining_next;
    logic [BYTE_W-1:0]  run_value_reg, run_value_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [POS_W-1:0]   col_reg, col_next;
    logic               done_reg, done_next;

    // output register
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [KIND_W-1:0]  m_kind_reg;
    logic               m_last_reg;

    // combinational result
    logic               res_valid;
    logic [BYTE_W-1:0]  res_value;
    logic [POS_W-1:0]   res_row;
    logic [POS_W-1:0]   res_col;
    logic [KIND_W-1:0]  res_kind;
    logic               res_last;

    // clamped geometry
    logic [DIM_W-1:0]   tw;
    logic [DIM_W-1:0]   th;
    logic [NP_W-1:0]    np;

    // emit path
    logic [BYTE_W-1:0]  ev;
    logic [DIM_W-1:0]   col_ext;
    logic               wrap0;
    logic [DIM_W-1:0]   e_row;
    logic [DIM_W-1:0]   e_col;
    logic               e_past;
    logic               e_last;
    logic [DIM_W-1:0]   e_col_inc;
    logic [DIM_W-1:0]   e_row_after;
    logic [POS_W-1:0]   e_col_after;
    logic [CNT_W-1:0]   rem_dec;
    logic [NP_W-1:0]    plane_inc;
    logic               fin;
    logic               s_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // clamp registers into their legal range
    assign tw = clamp_dim(tile_width_reg, dim_t'(TILE_EDGE));
    assign th = clamp_dim(tile_height_reg, dim_t'(TILE_EDGE));
    assign np = NP_W'(clamp_dim(dim_t'(bpp_reg), dim_t'(MAX_PLANES)));

    // position step for one written byte
    assign ev          = (s_tuser == MODE_PULL) ? run_value_reg : s_tdata;
    assign col_ext     = {1'b0, col_reg};
    assign wrap0       = col_ext >= tw;
    assign e_row       = wrap0 ? row_reg + DIM_W'(1) : row_reg;
    assign e_col       = wrap0 ? '0 : col_ext;
    assign e_past      = e_row >= th;
    assign plane_inc   = {1'b0, plane_reg} + NP_W'(1);
    assign e_last      = (plane_inc == np) && (e_row + DIM_W'(1) == th)
                         && (e_col + DIM_W'(1) == tw);
    assign e_col_inc   = e_col + DIM_W'(1);
    assign e_row_after = e_past ? e_row
                       : ((e_col_inc >= tw) ? e_row + DIM_W'(1) : e_row);
    assign e_col_after = e_past ? e_col[POS_W-1:0]
                       : ((e_col_inc >= tw) ? '0 : e_col_inc[POS_W-1:0]);
    assign rem_dec     = remaining_reg - CNT_W'(1);

    // decode one item
    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        run_value_next = run_value_reg;
        plane_next     = plane_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        done_next      = done_reg;
        fin            = 1'b0;
        res_valid      = 1'b0;
        res_value      = ev;
        res_row        = '0;
        res_col        = '0;
        res_kind       = KIND_WRITE;
        res_last       = 1'b0;

        if (s_tuser == MODE_NEW) begin
            phase_next     = PH_HDR;
            remaining_next = '0;
            run_value_next = '0;
            plane_next     = '0;
            row_next       = '0;
            col_next       = '0;
            done_next      = 1'b0;
        end else if (s_tuser == MODE_BYTE && (done_reg || phase_reg == PH_RUN)) begin
            res_valid = 1'b1;
            res_kind  = KIND_DROP_IN;
        end else if (s_tuser == MODE_PULL || (s_tuser == MODE_BYTE && phase_reg == PH_LIT)) begin
            // byte write: run pull or literal
            if (s_tuser == MODE_BYTE || (!done_reg && phase_reg == PH_RUN)) begin
                res_valid      = 1'b1;
                row_next       = e_row_after;
                col_next       = e_col_after;
                remaining_next = rem_dec;
                fin            = (rem_dec == '0);
                if (e_past) begin
                    res_kind = KIND_DROP_END;
                end else begin
                    res_row  = e_row[POS_W-1:0];
                    res_col  = e_col[POS_W-1:0];
                    res_last = e_last;
                end
            end
        end else if (s_tuser == MODE_BYTE) begin
            // header and count bytes
            unique case (phase_reg)
                PH_HDR: begin
                    if (s_tdata <= HDR_SHORT_RUN_MAX) begin
                        remaining_next = CNT_W'(s_tdata) + CNT_W'(1);
                        phase_next     = PH_VAL;
                    end else if (s_tdata == HDR_LONG_RUN) begin
                        phase_next = PH_RHI;
                    end else if (s_tdata == HDR_LONG_LIT) begin
                        phase_next = PH_CHI;
                    end else begin
                        remaining_next = CNT_W'(9'd256 - {1'b0, s_tdata});
                        phase_next     = PH_LIT;
                    end
                end
                PH_VAL: begin
                    run_value_next = s_tdata;
                    if (remaining_reg == '0) begin
                        fin = 1'b1;
                    end else begin
                        phase_next = PH_RUN;
                    end
                end
                PH_RHI: begin
                    remaining_next = {s_tdata, 8'd0};
                    phase_next     = PH_RLO;
                end
                PH_RLO: begin
                    remaining_next = {remaining_reg[CNT_W-1:BYTE_W], s_tdata};
                    phase_next     = PH_VAL;
                end
                PH_CHI: begin
                    remaining_next = {s_tdata, 8'd0};
                    phase_next     = PH_CLO;
                end
                PH_CLO: begin
                    remaining_next = {remaining_reg[CNT_W-1:BYTE_W], s_tdata};
                    if ({remaining_reg[CNT_W-1:BYTE_W], s_tdata} == '0) begin
                        fin = 1'b1;
                    end else begin
                        phase_next = PH_LIT;
                    end
                end
                default: begin
                    phase_next = PH_HDR;
                end
            endcase
        end

        // opcode complete: advance plane when full
        if (fin) begin
            phase_next     = PH_HDR;
            remaining_next = '0;
            if (row_next >= th) begin
                row_next = '0;
                col_next = '0;
                if (plane_inc >= np) begin
                    done_next = 1'b1;
                end else begin
                    plane_next = plane_inc[PLANE_W-1:0];
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg  <= DIM_W'(TILE_EDGE);
            tile_height_reg <= DIM_W'(TILE_EDGE);
            bpp_reg         <= NP_W'(MAX_PLANES);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data;
                REG_TILE_HEIGHT: tile_height_reg <= cfg_data;
                REG_BPP:         bpp_reg         <= cfg_data[NP_W-1:0];
                default: ;
            endcase
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR;
            remaining_reg <= '0;
            run_value_reg <= '0;
            plane_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            done_reg      <= 1'b0;
        end else if (s_fire) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            run_value_reg <= run_value_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            done_reg      <= done_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            m_data_reg <= {2'b00, res_col, res_row, plane_reg, res_value};
            m_kind_reg <= res_kind;
            m_last_reg <= res_last;
        end
    end

    // tile done only rests in the header phase
    a_done_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> phase_reg == PH_HDR)
        else $error("tile done outside header phase");

    // a pending run or literal always has bytes left
    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RUN || phase_reg == PH_LIT) |-> remaining_reg != '0)
        else $error("run or literal phase with zero count");

    // row never walks past the tile edge
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= DIM_W'(TILE_EDGE))
        else $error("row position past tile edge");

    // dropped items carry no position and no last flag
    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg != KIND_WRITE) |->
            (!m_last_reg && m_data_reg[M_DATA_W-3:BYTE_W+PLANE_W] == '0))
        else $error("dropped item with position or last set");

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the tile run-length plane decoder
module tb_top;
    import trpd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int ITEM_TARGET = 1250;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 8;

    // one decoded write as it leaves the block
    typedef struct packed {
        logic [7:0]        pix;
        logic [1:0]        plane;
        logic [5:0]        row;
        logic [5:0]        col;
        logic [KIND_W-1:0] kind;
        logic              last;
    } tile_write_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;
    // how an item's result is known: from the predictor, typed into the table, or none expected
    typedef enum logic [1:0] { CHK_PRED, CHK_NONE, CHK_RES } check_t;

    typedef struct packed {
        row_kind_t   rk;
        logic [1:0]  sel;   // mode for items, register index for writes
        logic [7:0]  val;
        check_t      chk;
        tile_write_t res;
    } script_row_t;

    localparam tile_write_t NO_WR = '0;
    localparam int SCRIPT_LEN = 27;

    // directed opening: reset geometry 64x64x4, then a 1x1 two-plane tile
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{ROW_ITEM, MODE_PULL, 8'h00, CHK_NONE, NO_WR},     // pull with nothing pending
        '{ROW_ITEM, MODE_NOP,  8'hFF, CHK_NONE, NO_WR},     // unused mode
        '{ROW_ITEM, MODE_BYTE, 8'h01, CHK_NONE, NO_WR},     // short run of two
        '{ROW_ITEM, MODE_BYTE, 8'hFF, CHK_NONE, NO_WR},     // run value
        '{ROW_ITEM, MODE_BYTE, 8'h5A, CHK_RES,
          '{8'h5A, 2'd0, 6'd0, 6'd0, KIND_DROP_IN, 1'b0}},  // byte while run pending
        '{ROW_ITEM, MODE_PULL, 8'h00, CHK_RES,
          '{8'hFF, 2'd0, 6'd0, 6'd0, KIND_WRITE, 1'b0}},
        '{ROW_ITEM, MODE_PULL, 8'h00, CHK_PRED, NO_WR},
        '{ROW_ITEM, MODE_PULL, 8'h00, CHK_NONE, NO_WR},     // run used up
        '{ROW_ITEM, MODE_BYTE, 8'h7F, CHK_NONE, NO_WR},     // long run, count zero
        '{ROW_ITEM, MODE_BYTE, 8'h00, CHK_NONE, NO_WR},
        '{ROW_ITEM, MODE_BYTE, 8'h00, CHK_NONE, NO_WR},
        '{ROW_ITEM, MODE_BYTE, 8'h33, CHK_NONE, NO_WR},
        '{ROW_ITEM, MODE_BYTE, 8'h80, CHK_NONE, NO_WR},     // long literal, count one
        '{ROW_ITEM, MODE_BYTE, 8'h00, CHK_NONE, NO_WR},
        '{ROW_ITEM, MODE_BYTE, 8'h01, CHK_NONE, NO_WR},
        '{ROW_ITEM, MODE_BYTE, 8'hA5, CHK_PRED, NO_WR},
        '{ROW_ITEM, MODE_NEW,  8'hFF, CHK_NONE, NO_WR},
        '{ROW_CFG,  REG_TILE_WIDTH,  8'd1, CHK_PRED, NO_WR},
        '{ROW_CFG,  REG_TILE_HEIGHT, 8'd1, CHK_PRED, NO_WR},
        '{ROW_CFG,  REG_BPP,         8'd2, CHK_PRED, NO_WR},
        '{ROW_ITEM, MODE_BYTE, 8'hFE, CHK_NONE, NO_WR},     // two literals
        '{ROW_ITEM, MODE_BYTE, 8'h81, CHK_RES,
          '{8'h81, 2'd0, 6'd0, 6'd0, KIND_WRITE, 1'b0}},
        '{ROW_ITEM, MODE_BYTE, 8'h42, CHK_RES,
          '{8'h42, 2'd0, 6'd0, 6'd0, KIND_DROP_END, 1'b0}}, // past plane end
        '{ROW_ITEM, MODE_BYTE, 8'h00, CHK_NONE, NO_WR},     // run of one, next plane
        '{ROW_ITEM, MODE_BYTE, 8'h99, CHK_NONE, NO_WR},
        '{ROW_ITEM, MODE_PULL, 8'h00, CHK_RES,
          '{8'h99, 2'd1, 6'd0, 6'd0, KIND_WRITE, 1'b1}},    // final write of the tile
        '{ROW_ITEM, MODE_BYTE, 8'h10, CHK_RES,
          '{8'h10, 2'd1, 6'd0, 6'd0, KIND_DROP_IN, 1'b0}}   // byte after tile done
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    // typed expectation travelling with the item on the input bus
    check_t      pin_chk = CHK_PRED;
    tile_write_t pin_exp = '0;

    tile_write_t pending_writes [$];
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int n_writes = 0, n_drop_in = 0, n_drop_end = 0, n_tile_ends = 0;
    int reg_writes = 0, settings_seen = 0;
    int tx_pace = 0;

    // decoder state as predicted
    logic [PHASE_W-1:0] dp_phase;
    logic [15:0]        dp_left;
    logic [7:0]         dp_run_val;
    logic [1:0]         dp_plane;
    logic [6:0]         dp_row;
    logic [6:0]         dp_col;
    logic               dp_done;
    logic [6:0]         cfg_width  = 7'd64;
    logic [6:0]         cfg_height = 7'd64;
    logic [2:0]         cfg_planes = 3'd4;

    tile_rle_plane_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int bounded(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic restart_tile();
        dp_phase   = PH_HDR;
        dp_left    = '0;
        dp_run_val = '0;
        dp_plane   = '0;
        dp_row     = '0;
        dp_col     = '0;
        dp_done    = 1'b0;
    endtask

    // place one byte at the current position, or flag it past the plane end
    task automatic place_byte(input logic [7:0] v, output tile_write_t wr);
        int tw, th, np;
        tw = bounded(int'(cfg_width), TILE_EDGE);
        th = bounded(int'(cfg_height), TILE_EDGE);
        np = bounded(int'(cfg_planes), MAX_PLANES);
        wr = '{pix: v, plane: dp_plane, row: 6'd0, col: 6'd0, kind: KIND_WRITE, last: 1'b0};
        if (dp_col >= tw) begin
            dp_col = '0;
            dp_row = dp_row + 7'd1;
        end
        if (dp_row >= th) begin
            wr.kind = KIND_DROP_END;
        end else begin
            wr.row  = dp_row[5:0];
            wr.col  = dp_col[5:0];
            wr.last = (int'(dp_plane) + 1 == np) && (int'(dp_row) + 1 == th) &&
                      (int'(dp_col) + 1 == tw);
            dp_col = dp_col + 7'd1;
            if (dp_col >= tw) begin
                dp_col = '0;
                dp_row = dp_row + 7'd1;
            end
        end
    endtask

    // opcode complete: step to the next plane once this one is full
    task automatic close_opcode();
        int th, np;
        th = bounded(int'(cfg_height), TILE_EDGE);
        np = bounded(int'(cfg_planes), MAX_PLANES);
        dp_phase = PH_HDR;
        dp_left  = '0;
        if (dp_row >= th) begin
            dp_row = '0;
            dp_col = '0;
            if (int'(dp_plane) + 1 >= np) begin
                dp_done = 1'b1;
            end else begin
                dp_plane = dp_plane + 2'd1;
            end
        end
    endtask

    // next state and result, if any, for one accepted item
    task automatic decode_item(input logic [1:0] mode, input logic [7:0] b,
                               output bit produced, output tile_write_t wr);
        produced = 1'b0;
        wr = '0;
        case (mode)
            MODE_NEW: begin
                restart_tile();
            end
            MODE_PULL: begin
                if (!dp_done && dp_phase == PH_RUN) begin
                    place_byte(dp_run_val, wr);
                    produced = 1'b1;
                    dp_left = dp_left - 16'd1;
                    if (dp_left == '0) close_opcode();
                end
            end
            MODE_BYTE: begin
                if (dp_done || dp_phase == PH_RUN) begin
                    wr = '{pix: b, plane: dp_plane, row: 6'd0, col: 6'd0,
                           kind: KIND_DROP_IN, last: 1'b0};
                    produced = 1'b1;
                end else begin
                    case (dp_phase)
                        PH_HDR: begin
                            if (b <= HDR_SHORT_RUN_MAX) begin
                                dp_left  = 16'(b) + 16'd1;
                                dp_phase = PH_VAL;
                            end else if (b == HDR_LONG_RUN) begin
                                dp_phase = PH_RHI;
                            end else if (b == HDR_LONG_LIT) begin
                                dp_phase = PH_CHI;
                            end else begin
                                dp_left  = 16'd256 - 16'(b);
                                dp_phase = PH_LIT;
                            end
                        end
                        PH_VAL: begin
                            dp_run_val = b;
                            if (dp_left == '0) close_opcode();
                            else dp_phase = PH_RUN;
                        end
                        PH_RHI: begin
                            dp_left  = {b, 8'h00};
                            dp_phase = PH_RLO;
                        end
                        PH_RLO: begin
                            dp_left  = {dp_left[15:8], b};
                            dp_phase = PH_VAL;
                        end
                        PH_CHI: begin
                            dp_left  = {b, 8'h00};
                            dp_phase = PH_CLO;
                        end
                        PH_CLO: begin
                            dp_left = {dp_left[15:8], b};
                            if (dp_left == '0) close_opcode();
                            else dp_phase = PH_LIT;
                        end
                        PH_LIT: begin
                            place_byte(b, wr);
                            produced = 1'b1;
                            dp_left = dp_left - 16'd1;
                            if (dp_left == '0) close_opcode();
                        end
                        default: begin
                            dp_phase = PH_HDR;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (e !== a) begin
            $display("%0t: %s expected %0h got %0h", $time, name, e, a);
            errors++;
        end
    endtask

    // predict on input items, compare on result items
    always @(posedge aclk) begin : scoreboard
        bit produced;
        tile_write_t guess;
        tile_write_t seen;
        tile_write_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TILE_WIDTH:  cfg_width  = cfg_data;
                    REG_TILE_HEIGHT: cfg_height = cfg_data;
                    REG_BPP:         cfg_planes = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_item(s_tuser, s_tdata, produced, guess);
                case (pin_chk)
                    CHK_PRED: if (produced) pending_writes = {pending_writes, guess};
                    CHK_RES:  pending_writes = {pending_writes, pin_exp};
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                seen = '{pix: m_tdata[7:0], plane: m_tdata[9:8], row: m_tdata[15:10],
                         col: m_tdata[21:16], kind: m_tuser, last: m_tlast};
                results_checked++;
                case (seen.kind)
                    KIND_WRITE:    n_writes++;
                    KIND_DROP_IN:  n_drop_in++;
                    KIND_DROP_END: n_drop_end++;
                    default: ;
                endcase
                if (seen.last) n_tile_ends++;
                if (pending_writes.size() == 0) begin
                    $display("%0t: unexpected result, expected none got %h", $time, seen);
                    errors++;
                end else begin
                    want = pending_writes.pop_front();
                    flag_field("pixel_value", want.pix, seen.pix);
                    flag_field("plane", 8'(want.plane), 8'(seen.plane));
                    flag_field("tile_row", 8'(want.row), 8'(seen.row));
                    flag_field("tile_col", 8'(want.col), 8'(seen.col));
                    flag_field("kind", 8'(want.kind), 8'(seen.kind));
                    flag_field("last", 8'(want.last), 8'(seen.last));
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin : watchdog
        int quiet;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= STALL_LIMIT) begin
                    $display("%0t: no progress for %0d cycles", $time, quiet);
                    $display("tile_rle_plane_decoder: mismatch");
                    $finish;
                end
            end
        end
    end

    // result side: paced stretches, rare long stalls, one long hold-off under load
    initial begin : receiver
        bit held;
        int pace;
        int span;
        held = 1'b0;
        span = 0;
        pace = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && results_checked >= 300 && s_tvalid) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (span == 0) begin
                    case ($urandom_range(0, 2))
                        0: pace = 0;
                        1: pace = 30;
                        default: pace = 60;
                    endcase
                    span = $urandom_range(20, 120);
                end
                span--;
                if (pace != 0 && $urandom_range(0, 199) == 0) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end else begin
                    m_tready <= (pace == 0) || ($urandom_range(0, 99) >= pace);
                    @(posedge aclk);
                end
            end
        end
    end

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_pace == 0 || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(input logic [1:0] mode, input logic [7:0] b,
                             input check_t chk, input tile_write_t exp);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        pin_chk  <= chk;
        pin_exp  <= exp;
        do @(posedge aclk); while (!s_tready);
        if (mode != MODE_NOP) items_sent++;
    endtask

    task automatic feed(input logic [1:0] mode, input logic [7:0] b);
        send_item(mode, b, CHK_PRED, NO_WR);
    endtask

    // stop offering and let every expected result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge aclk);
    endtask

    // pulls for a run, now and then with a stray byte or a spare pull
    task automatic run_pulls(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) feed(MODE_BYTE, 8'($urandom));
            feed(MODE_PULL, 8'($urandom));
        end
        if ($urandom_range(0, 5) == 0) feed(MODE_PULL, 8'($urandom));
    endtask

    task automatic literal_bytes(input int n);
        repeat (n) feed(MODE_BYTE, 8'($urandom));
    endtask

    function automatic logic [6:0] pick_dim();
        case ($urandom_range(0, 15))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            4: return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    // one tile's worth of opcodes with random content and the odd broken sequence
    task automatic tile_stream(input bit fresh);
        int tw, th, np, pl, left, n, ops, op, r;
        tw = bounded(int'(cfg_width), TILE_EDGE);
        th = bounded(int'(cfg_height), TILE_EDGE);
        np = bounded(int'(cfg_planes), MAX_PLANES);
        if (fresh) feed(MODE_NEW, 8'($urandom));
        for (pl = 0; pl < np; pl++) begin
            left = tw * th;
            ops = 0;
            while (left > 0 && ops < 6 && items_sent < ITEM_TARGET) begin
                ops++;
                if ($urandom_range(0, 19) == 0) begin
                    feed(2'($urandom_range(0, 3)), 8'($urandom));
                end
                op = $urandom_range(0, 3);
                if ($urandom_range(0, 29) == 0) begin
                    // huge count, cut short by a new tile
                    r = $urandom_range(0, 1);
                    feed(MODE_BYTE, r ? HDR_LONG_RUN : HDR_LONG_LIT);
                    feed(MODE_BYTE, 8'($urandom_range(1, 255)));
                    feed(MODE_BYTE, 8'($urandom));
                    if (r) feed(MODE_BYTE, 8'($urandom));
                    repeat ($urandom_range(0, 5)) feed(r ? MODE_PULL : MODE_BYTE, 8'($urandom));
                    feed(MODE_NEW, 8'($urandom));
                    return;
                end
                if ((op == 1 || op == 2) && $urandom_range(0, 9) == 0) begin
                    // zero count completes at once
                    feed(MODE_BYTE, (op == 1) ? HDR_LONG_RUN : HDR_LONG_LIT);
                    feed(MODE_BYTE, 8'h00);
                    feed(MODE_BYTE, 8'h00);
                    if (op == 1) feed(MODE_BYTE, 8'($urandom));
                    continue;
                end
                r = $urandom_range(0, 9);
                if (r < 6) n = $urandom_range(1, (left < 6) ? left : 6);
                else if (r < 9 || left > 60) n = $urandom_range(1, (left < 127) ? left : 127);
                else n = left + $urandom_range(1, 3);
                if (n > 127 && (op == 0 || op == 3)) op = (op == 0) ? 1 : 2;
                case (op)
                    0: begin
                        feed(MODE_BYTE, 8'(n - 1));
                        feed(MODE_BYTE, 8'($urandom));
                        run_pulls(n);
                    end
                    1: begin
                        feed(MODE_BYTE, HDR_LONG_RUN);
                        feed(MODE_BYTE, 8'(n >> 8));
                        feed(MODE_BYTE, 8'(n));
                        feed(MODE_BYTE, 8'($urandom));
                        run_pulls(n);
                    end
                    2: begin
                        feed(MODE_BYTE, HDR_LONG_LIT);
                        feed(MODE_BYTE, 8'(n >> 8));
                        feed(MODE_BYTE, 8'(n));
                        literal_bytes(n);
                    end
                    default: begin
                        feed(MODE_BYTE, 8'(256 - n));
                        literal_bytes(n);
                    end
                endcase
                left = (n >= left) ? 0 : left - n;
            end
        end
        if ($urandom_range(0, 1) == 0) begin
            feed(MODE_BYTE, 8'($urandom));
            feed(MODE_PULL, 8'($urandom));
        end
    endtask

    // main sequence
    initial begin : stimulus
        int i;
        restart_tile();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].rk == ROW_CFG) begin
                set_reg(SCRIPT[i].sel, SCRIPT[i].val[6:0]);
            end else begin
                send_item(SCRIPT[i].sel, SCRIPT[i].val, SCRIPT[i].chk, SCRIPT[i].res);
            end
        end

        while (items_sent < ITEM_TARGET) begin
            set_reg(REG_TILE_WIDTH, pick_dim());
            set_reg(REG_TILE_HEIGHT, pick_dim());
            // upper bits of the plane count are junk the block must ignore
            set_reg(REG_BPP, ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 7)));
            settings_seen++;
            tx_pace = $urandom_range(0, 2);
            // sometimes keep the current tile so the new geometry lands mid-tile
            tile_stream($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 3)) begin
                if (items_sent < ITEM_TARGET) tile_stream(1'b1);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_writes.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_writes.size());
            errors += pending_writes.size();
        end
        $display("covered %0d items over %0d register settings (%0d register writes)",
                 items_sent, settings_seen, reg_writes);
        $display("results %0d: %0d writes, %0d dropped inputs, %0d past plane end, %0d tile ends",
                 results_checked, n_writes, n_drop_in, n_drop_end, n_tile_ends);
        if (errors == 0) begin
            $display("tile_rle_plane_decoder: match");
        end else begin
            $display("tile_rle_plane_decoder: mismatch");
        end
        $finish;
    end

endmodule
